@@ design/tcfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_pkg
// Shared types and constants for the ClientHello field extractor.
// ----------------------------------------------------------------------------
package tcfe_pkg;

  localparam logic [15:0] MAX_RECORD_BYTES = 16'hffff;
  localparam int          QDEPTH           = 4;
  localparam int          QAW              = $clog2(QDEPTH);
  localparam int          QCW              = $clog2(QDEPTH + 1);

  localparam logic [7:0]  REC_HANDSHAKE    = 8'h16;
  localparam logic [7:0]  HS_TYPE_HELLO    = 8'h01;
  localparam logic [15:0] EXT_SNI          = 16'h0000;
  localparam logic [15:0] EXT_GROUPS       = 16'h000a;
  localparam logic [15:0] EXT_EC_FORMATS   = 16'h000b;
  localparam logic [15:0] EXT_SIGNATURES   = 16'h000d;
  localparam logic [15:0] EXT_APP_PROTO    = 16'h0010;
  localparam logic [15:0] EXT_SUP_VERSIONS = 16'h002b;
  localparam logic [15:0] GREASE_MASK      = 16'h0f0f;
  localparam logic [15:0] GREASE_PATTERN   = 16'h0a0a;

  localparam logic [3:0]  KIND_CIPHER      = 4'd0;
  localparam logic [3:0]  KIND_EXT_TYPE    = 4'd1;
  localparam logic [3:0]  KIND_GROUP       = 4'd2;
  localparam logic [3:0]  KIND_EC_FORMAT   = 4'd3;
  localparam logic [3:0]  KIND_SIG_ALG     = 4'd4;
  localparam logic [3:0]  KIND_SNI_BYTE    = 4'd5;
  localparam logic [3:0]  KIND_ALPN_BYTE   = 4'd6;
  localparam logic [3:0]  KIND_ALPN_EMPTY  = 4'd7;
  localparam logic [3:0]  KIND_SUMMARY     = 4'd8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic        is_grease;
    logic        piece_end;
    logic [15:0] client_version;
    logic        sni_present;
    logic        hello_valid;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } qwrite_t;

  function automatic logic grease16(input logic [15:0] v);
    return ((v & GREASE_MASK) == GREASE_PATTERN) && (v[15:8] == v[7:0]);
  endfunction

endpackage

@@ design/tcfe_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_parser
// Front end: walks the record byte by byte and classifies each into results.
// ----------------------------------------------------------------------------
module tcfe_parser import tcfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic [15:0] held_length,
  input  logic        last_byte,
  output qwrite_t     wr
);

  typedef enum logic [4:0] {
    PH_HEAD = 5'd0, PH_LEGACY = 5'd1, PH_RANDOM = 5'd2, PH_SID_LEN = 5'd3,
    PH_SID = 5'd4, PH_CS_LEN = 5'd5, PH_CS_ITEM = 5'd6, PH_CM_LEN = 5'd7,
    PH_CM = 5'd8, PH_EXT_LEN = 5'd9, PH_EH_TYPE = 5'd10, PH_EH_LEN = 5'd11,
    PH_SKIP = 5'd12, PH_SNI_LIST = 5'd13, PH_SNI_TYPE = 5'd14,
    PH_SNI_NLEN = 5'd15, PH_SNI_NAME = 5'd16, PH_VEC_LEN = 5'd17,
    PH_VEC_ITEM = 5'd18, PH_EC_N = 5'd19, PH_EC_ITEM = 5'd20,
    PH_SV_N = 5'd21, PH_SV_ITEM = 5'd22, PH_AL_LIST = 5'd23,
    PH_AL_PLEN = 5'd24, PH_AL_BYTES = 5'd25, PH_DONE = 5'd26
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] ext_end_r, ext_end_nxt;
  logic [15:0] body_end_r, body_end_nxt;
  logic [15:0] ext_kind_r, ext_kind_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        pair_r, pair_nxt;
  logic [15:0] legacy_r, legacy_nxt;
  logic [15:0] best_r, best_nxt;
  logic        sni_r, sni_nxt;
  logic        anyc_r, anyc_nxt;
  logic        anye_r, anye_nxt;
  logic        fail_r, fail_nxt;

  logic [15:0] eff_len, nx, rec_left, body_left, pv, vtot, ext_nx;
  logic [17:0] nx_w, sum_w;
  logic        was_body, elem_vld, sum_vld, entry, hello_ok;
  result_t     elem, summ;

  always_comb begin
    phase_nxt = phase_r;  pos_nxt = pos_r;  rem_nxt = rem_r;
    ext_end_nxt = ext_end_r;  body_end_nxt = body_end_r;
    ext_kind_nxt = ext_kind_r;  high_nxt = high_r;  pair_nxt = pair_r;
    legacy_nxt = legacy_r;  best_nxt = best_r;  sni_nxt = sni_r;
    anyc_nxt = anyc_r;  anye_nxt = anye_r;  fail_nxt = fail_r;
    elem_vld = 1'b0;  elem = '0;  sum_vld = 1'b0;  summ = '0;
    entry = 1'b0;  hello_ok = 1'b0;  vtot = '0;  ext_nx = '0;

    eff_len   = (held_length > MAX_RECORD_BYTES) ? MAX_RECORD_BYTES : held_length;
    nx        = pos_r + 16'd1;
    nx_w      = {2'b00, nx};
    rec_left  = eff_len - nx;
    body_left = (body_end_r > nx) ? (body_end_r - nx) : 16'd0;
    pv        = {high_r, data_byte};
    was_body  = (phase_r >= PH_SKIP) && (phase_r <= PH_AL_BYTES);
    sum_w     = nx_w + {2'b00, pv};

    if (fire && (pos_r < eff_len)) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (((pos_r == 16'd0) && (data_byte != REC_HANDSHAKE)) ||
              ((pos_r == 16'd5) && (data_byte != HS_TYPE_HELLO))) begin
            fail_nxt = 1'b1;  phase_nxt = PH_DONE;  pair_nxt = 1'b0;
          end else if (pos_r >= 16'd8) begin
            phase_nxt = PH_LEGACY;  pair_nxt = 1'b0;
          end
        end
        PH_LEGACY: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            legacy_nxt = pv;  rem_nxt = 16'd32;
            phase_nxt = PH_RANDOM;  pair_nxt = 1'b0;
          end
        end
        PH_RANDOM, PH_SID, PH_CM: begin
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            pair_nxt = 1'b0;
            unique case (phase_r)
              PH_RANDOM: phase_nxt = PH_SID_LEN;
              PH_SID:    phase_nxt = PH_CS_LEN;
              default:   phase_nxt = PH_EXT_LEN;
            endcase
          end
        end
        PH_SID_LEN, PH_CM_LEN: begin
          pair_nxt = 1'b0;
          if ({8'h00, data_byte} > rec_left) begin
            fail_nxt = 1'b1;  phase_nxt = PH_DONE;
          end else if (data_byte == 8'h00) begin
            phase_nxt = (phase_r == PH_SID_LEN) ? PH_CS_LEN : PH_EXT_LEN;
          end else begin
            rem_nxt = {8'h00, data_byte};
            phase_nxt = (phase_r == PH_SID_LEN) ? PH_SID : PH_CM;
          end
        end
        PH_CS_LEN: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            if (pv > rec_left) begin
              fail_nxt = 1'b1;  phase_nxt = PH_DONE;
            end else if (pv == 16'd0) begin
              phase_nxt = PH_CM_LEN;
            end else begin
              rem_nxt = pv;  phase_nxt = PH_CS_ITEM;
            end
          end
        end
        PH_CS_ITEM, PH_VEC_ITEM: begin
          if (!pair_r) begin
            if (rem_r >= 16'd2) begin
              high_nxt = data_byte;  pair_nxt = 1'b1;
            end
          end else begin
            pair_nxt = 1'b0;
            elem_vld = 1'b1;
            elem.value = pv;
            elem.is_grease = grease16(pv);
            if (phase_r == PH_CS_ITEM) begin
              elem.kind = KIND_CIPHER;  anyc_nxt = 1'b1;
            end else begin
              elem.kind = (ext_kind_r == EXT_GROUPS) ? KIND_GROUP : KIND_SIG_ALG;
            end
          end
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            pair_nxt = 1'b0;
            phase_nxt = (phase_r == PH_CS_ITEM) ? PH_CM_LEN : PH_SKIP;
          end
        end
        PH_EXT_LEN: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            vtot = (pv > rec_left) ? rec_left : pv;
            ext_end_nxt = nx + vtot;
            entry = 1'b1;
          end
        end
        PH_EH_TYPE: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            ext_kind_nxt = pv;  phase_nxt = PH_EH_LEN;  pair_nxt = 1'b0;
          end
        end
        PH_EH_LEN: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            if (sum_w > {2'b00, ext_end_r}) begin
              phase_nxt = PH_DONE;
            end else begin
              elem_vld = 1'b1;
              elem.kind = KIND_EXT_TYPE;
              elem.value = ext_kind_r;
              elem.is_grease = grease16(ext_kind_r);
              anye_nxt = 1'b1;
              body_end_nxt = sum_w[15:0];
              case (ext_kind_r)
                EXT_SNI:          phase_nxt = PH_SNI_LIST;
                EXT_GROUPS:       phase_nxt = PH_VEC_LEN;
                EXT_SIGNATURES:   phase_nxt = PH_VEC_LEN;
                EXT_EC_FORMATS:   phase_nxt = PH_EC_N;
                EXT_SUP_VERSIONS: phase_nxt = PH_SV_N;
                EXT_APP_PROTO:    phase_nxt = PH_AL_LIST;
                default:          phase_nxt = PH_SKIP;
              endcase
              if (pv == 16'd0) entry = 1'b1;
            end
          end
        end
        PH_SKIP: begin
        end
        PH_SNI_LIST, PH_AL_LIST: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            phase_nxt = (phase_r == PH_SNI_LIST) ? PH_SNI_TYPE : PH_AL_PLEN;
          end
        end
        PH_SNI_TYPE: begin
          pair_nxt = 1'b0;
          phase_nxt = (data_byte != 8'h00) ? PH_SKIP : PH_SNI_NLEN;
        end
        PH_SNI_NLEN: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            phase_nxt = PH_SKIP;
            if (pv <= body_left) begin
              sni_nxt = 1'b1;
              if (pv != 16'd0) begin
                rem_nxt = pv;  phase_nxt = PH_SNI_NAME;
              end
            end
          end
        end
        PH_SNI_NAME, PH_AL_BYTES: begin
          elem_vld = 1'b1;
          elem.kind = (phase_r == PH_SNI_NAME) ? KIND_SNI_BYTE : KIND_ALPN_BYTE;
          elem.value = {8'h00, data_byte};
          elem.piece_end = (rem_r == 16'd1);
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            pair_nxt = 1'b0;
            phase_nxt = (phase_r == PH_SNI_NAME) ? PH_SKIP : PH_AL_PLEN;
          end
        end
        PH_VEC_LEN: begin
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            if ((pv == 16'd0) || (pv > body_left)) begin
              phase_nxt = PH_SKIP;
            end else begin
              rem_nxt = pv;  phase_nxt = PH_VEC_ITEM;
            end
          end
        end
        PH_EC_N, PH_SV_N: begin
          pair_nxt = 1'b0;
          if ((phase_r == PH_EC_N) ? (data_byte == 8'h00) : (data_byte < 8'd2)) begin
            phase_nxt = PH_SKIP;
          end else begin
            rem_nxt = {8'h00, data_byte};
            phase_nxt = (phase_r == PH_EC_N) ? PH_EC_ITEM : PH_SV_ITEM;
          end
        end
        PH_EC_ITEM: begin
          elem_vld = 1'b1;
          elem.kind = KIND_EC_FORMAT;
          elem.value = {8'h00, data_byte};
          elem.is_grease = grease16({8'h00, data_byte});
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            pair_nxt = 1'b0;  phase_nxt = PH_SKIP;
          end
        end
        PH_SV_ITEM: begin
          rem_nxt = rem_r - 16'd1;
          if (!pair_r) begin
            high_nxt = data_byte;  pair_nxt = 1'b1;
          end else begin
            pair_nxt = 1'b0;
            if (!grease16(pv) && (pv > best_r)) best_nxt = pv;
            if (rem_nxt < 16'd2) phase_nxt = PH_SKIP;
          end
        end
        PH_AL_PLEN: begin
          pair_nxt = 1'b0;
          if ({8'h00, data_byte} > body_left) begin
            phase_nxt = PH_SKIP;
          end else if (data_byte == 8'h00) begin
            elem_vld = 1'b1;
            elem.kind = KIND_ALPN_EMPTY;
            elem.piece_end = 1'b1;
          end else begin
            rem_nxt = {8'h00, data_byte};  phase_nxt = PH_AL_BYTES;
          end
        end
        default: begin
          phase_nxt = PH_DONE;  pair_nxt = 1'b0;
        end
      endcase

      if (was_body && (phase_nxt != PH_DONE) && (nx >= body_end_r)) entry = 1'b1;
      if (entry) begin
        pair_nxt = 1'b0;
        phase_nxt = ((nx_w + 18'd4) <= {2'b00, ext_end_nxt}) ? PH_EH_TYPE : PH_DONE;
      end
    end

    if (fire && (pos_r != 16'hffff)) pos_nxt = pos_r + 16'd1;

    if (fire && last_byte) begin
      hello_ok = !fail_nxt && (pos_nxt >= eff_len) && (phase_nxt >= PH_EXT_LEN) &&
                 (anyc_nxt || anye_nxt);
      sum_vld = 1'b1;
      summ.kind = KIND_SUMMARY;
      summ.value = (best_nxt != 16'd0) ? best_nxt : legacy_nxt;
      summ.client_version = legacy_nxt;
      summ.sni_present = sni_nxt;
      summ.hello_valid = hello_ok;
      summ.run_last = 1'b1;
      phase_nxt = PH_HEAD;  pos_nxt = '0;  rem_nxt = '0;  ext_end_nxt = '0;
      body_end_nxt = '0;  ext_kind_nxt = '0;  high_nxt = '0;  pair_nxt = 1'b0;
      legacy_nxt = '0;  best_nxt = '0;  sni_nxt = 1'b0;  anyc_nxt = 1'b0;
      anye_nxt = 1'b0;  fail_nxt = 1'b0;
    end
    elem.run_last = !sum_vld;

    ext_nx = nx;
    wr = '0;
    if (elem_vld && sum_vld) begin
      wr.cnt = 2'd2;  wr.first = elem;  wr.second = summ;
    end else if (elem_vld) begin
      wr.cnt = 2'd1;  wr.first = elem;
    end else if (sum_vld) begin
      wr.cnt = 2'd1;  wr.first = summ;
    end
    wr.second.value = (elem_vld && sum_vld) ? summ.value : ext_nx & 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;  pos_r <= '0;  rem_r <= '0;  ext_end_r <= '0;
      body_end_r <= '0;  ext_kind_r <= '0;  high_r <= '0;  pair_r <= 1'b0;
      legacy_r <= '0;  best_r <= '0;  sni_r <= 1'b0;  anyc_r <= 1'b0;
      anye_r <= 1'b0;  fail_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;  pos_r <= pos_nxt;  rem_r <= rem_nxt;
      ext_end_r <= ext_end_nxt;  body_end_r <= body_end_nxt;
      ext_kind_r <= ext_kind_nxt;  high_r <= high_nxt;  pair_r <= pair_nxt;
      legacy_r <= legacy_nxt;  best_r <= best_nxt;  sni_r <= sni_nxt;
      anyc_r <= anyc_nxt;  anye_r <= anye_nxt;  fail_r <= fail_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pair_only_in_pair_phases: assert property (@(posedge clk) disable iff (!rst_n)
    pair_r |-> (phase_r != PH_HEAD) && (phase_r != PH_DONE) && (phase_r != PH_SKIP))
    else $error("half-gathered pair outside a 16-bit field");
  a_summary_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_byte) |=> (phase_r == PH_HEAD) && (pos_r == 16'd0) && !fail_r)
    else $error("state not cleared after summary");
  a_fail_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |-> (phase_r == PH_DONE))
    else $error("failed parse left done phase");
`endif

endmodule

@@ design/tcfe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_queue
// Back end: result queue taking up to two words a cycle, giving one a cycle.
// ----------------------------------------------------------------------------
module tcfe_queue import tcfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  qwrite_t wr,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t        mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] count_r;
  logic           rd;
  logic [QAW-1:0] wp_plus;

  assign empty   = (count_r == '0);
  assign full    = (count_r > QCW'(QDEPTH - 2));
  assign rd      = pop && !empty;
  assign head    = mem_r[rp_r];
  assign wp_plus = wp_r + QAW'(1);

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) mem_r[wp_r] <= wr.first;
    if (wr.cnt == 2'd2) mem_r[wp_plus] <= wr.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;  rp_r <= '0;  count_r <= '0;
    end else begin
      wp_r    <= wp_r + QAW'(wr.cnt);
      rp_r    <= rp_r + QAW'(rd);
      count_r <= count_r + QCW'(wr.cnt) - QCW'(rd);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue overflow");
  a_room_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt != 2'd0) |-> ({1'b0, count_r} + (QCW + 1)'(wr.cnt) <= (QCW + 1)'(QDEPTH)))
    else $error("write without room");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd && (wr.cnt == 2'd0)) |=> (count_r == $past(count_r) - QCW'(1)))
    else $error("pop did not drain");
`endif

endmodule

@@ design/tls_client_hello_field_extractor_core.sv @@
`timescale 1ns / 1ps
// A result is queued as its byte is taken and shows on out_ when at the head.
// Throughput: one record byte per cycle while the queue is not full; the
// parser updates counters and phase on each byte taken, and a four-word result
// queue absorbs the final byte's element plus summary. Reset (rst_n low,
// synchronous) returns the parser to the record header and empties the queue.
// ----------------------------------------------------------------------------
// tls_client_hello_field_extractor_core
// Streams a held TLS record and extracts ClientHello fields and a summary.
// ----------------------------------------------------------------------------
module tls_client_hello_field_extractor_core import tcfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_held_length,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_kind,
  output logic [15:0] out_value,
  output logic        out_is_grease,
  output logic        out_piece_end,
  output logic [15:0] out_client_version,
  output logic        out_sni_present,
  output logic        out_hello_valid,
  output logic        out_run_last
);

  qwrite_t wr;
  result_t head;
  logic    fire;

  assign fire = push && !full;

  tcfe_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_byte),
    .held_length (in_held_length),
    .last_byte   (in_last_byte),
    .wr          (wr)
  );

  tcfe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign out_kind           = head.kind;
  assign out_value          = head.value;
  assign out_is_grease      = head.is_grease;
  assign out_piece_end      = head.piece_end;
  assign out_client_version = head.client_version;
  assign out_sni_present    = head.sni_present;
  assign out_hello_valid    = head.hello_valid;
  assign out_run_last       = head.run_last;

endmodule
